@@ hdl/ist_pkg.sv @@
// Shared constants, codes and types of the integer set table.
package ist_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VAL_W = 32;
  localparam int OUT_CNT_W = 7;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT = 3'd1;
  localparam logic [2:0] ST_REMOVED = 3'd2;
  localparam logic [2:0] ST_ABSENT = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic compare;
    logic write;
    logic shift;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] count;
    logic [VAL_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ hdl/integer_set_table.sv @@
// Top level of the integer set table: a row of entry cells and the request sequencer.
//
// A request carries a mode (insert, remove or query) and a 32-bit value and is
// taken on req_valid and req_ready. Each request gives exactly one response on
// rsp_valid and rsp_ready with a status, a found flag, the entry count and an
// empty flag. Entries are kept in insertion order in a row of cells, one value
// per cell; all cells compare the value at once, and on a remove the hit cell
// and every cell above it take the values of their upper neighbours together.
// A request is taken in the idle state, where the cells compare its value; the
// outcome is decided and registered, and the response made valid, in the decide
// state, which waits while an earlier response is pending; no new request is
// taken until that state is left. The response waits in its register while the
// receiver stalls; the next request is still taken, but its outcome is held
// back until the waiting response has gone. Reset empties the table and drops
// any pending response; entry storage itself is not cleared.
module integer_set_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      mode,
  input  logic signed [31:0]              value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [2:0]                      status,
  output logic                            found,
  output logic [6:0]                      entry_count,
  output logic                            is_empty
);

  ist_pkg::cell_cmd_t                 cmd;
  logic [ist_pkg::CAPACITY-1:0]       match;
  logic [ist_pkg::VAL_W-1:0]          entries [ist_pkg::CAPACITY];

  ist_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .mode        (mode),
    .value       (value),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .found       (found),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .match       (match),
    .cmd         (cmd)
  );

  for (genvar i = 0; i < ist_pkg::CAPACITY; i++) begin : g_cell
    logic [ist_pkg::VAL_W-1:0] upper;

    if (i == ist_pkg::CAPACITY - 1) begin : g_last
      assign upper = entries[i];
    end else begin : g_mid
      assign upper = entries[i + 1];
    end

    ist_cell u_cell (
      .clk         (clk),
      .idx         (ist_pkg::IDX_W'(i)),
      .cmd         (cmd),
      .upper_value (upper),
      .entry       (entries[i]),
      .match       (match[i])
    );
  end

endmodule

@@ hdl/ist_cell.sv @@
// One table entry: holds a value, compares it and takes its upper neighbour's value on remove.
module ist_cell (
  input  logic                                 clk,
  input  logic [ist_pkg::IDX_W-1:0]            idx,
  input  ist_pkg::cell_cmd_t                   cmd,
  input  logic [ist_pkg::VAL_W-1:0]            upper_value,
  output logic [ist_pkg::VAL_W-1:0]            entry,
  output logic                                 match
);

  logic [ist_pkg::CNT_W-1:0] idx_wide;
  logic                      occupied;

  assign idx_wide = ist_pkg::CNT_W'(idx);
  assign occupied = idx_wide < cmd.count;

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      match <= occupied && (entry == cmd.value);
    end
    if (cmd.write && (idx_wide == cmd.count)) begin
      entry <= cmd.value;
    end else if (cmd.shift && (idx >= cmd.pos)) begin
      entry <= upper_value;
    end
  end

endmodule

@@ hdl/ist_ctrl.sv @@
// Request sequencer: decides the outcome, keeps the count and holds the result register.
module ist_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic [1:0]                      mode,
  input  logic signed [31:0]              value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [2:0]                      status,
  output logic                            found,
  output logic [ist_pkg::OUT_CNT_W-1:0]   entry_count,
  output logic                            is_empty,
  input  logic [ist_pkg::CAPACITY-1:0]    match,
  output ist_pkg::cell_cmd_t              cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_DECIDE = 2'b10
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [1:0]                    mode_q;
  logic [ist_pkg::VAL_W-1:0]     value_q;
  logic [ist_pkg::CNT_W-1:0]     count;
  logic [ist_pkg::CNT_W-1:0]     count_next;
  logic [ist_pkg::IDX_W-1:0]     pos;
  logic                          hit;
  logic                          full;
  logic                          decide;
  logic                          accept;
  logic                          do_insert;
  logic                          do_remove;
  logic [2:0]                    status_next;

  assign req_ready = (state == S_IDLE);
  assign accept = req_valid && req_ready;
  assign decide = (state == S_DECIDE) && (!rsp_valid || rsp_ready);
  assign hit = |match;
  assign full = (count == ist_pkg::CNT_W'(ist_pkg::CAPACITY));

  always_comb begin
    pos = '0;
    for (int i = 0; i < ist_pkg::CAPACITY; i++) begin
      if (match[i]) begin
        pos = pos | ist_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    count_next = count;
    unique case (mode_q)
      ist_pkg::MODE_INSERT: begin
        if (hit) begin
          status_next = ist_pkg::ST_PRESENT;
        end else if (full) begin
          status_next = ist_pkg::ST_FULL;
        end else begin
          status_next = ist_pkg::ST_INSERTED;
          do_insert = 1'b1;
          count_next = count + ist_pkg::CNT_W'(1);
        end
      end
      ist_pkg::MODE_REMOVE: begin
        if (hit) begin
          status_next = ist_pkg::ST_REMOVED;
          do_remove = 1'b1;
          count_next = count - ist_pkg::CNT_W'(1);
        end else begin
          status_next = ist_pkg::ST_ABSENT;
        end
      end
      default: begin
        status_next = hit ? ist_pkg::ST_PRESENT : ist_pkg::ST_ABSENT;
      end
    endcase
  end

  always_comb begin
    cmd.compare = accept;
    cmd.write = decide && do_insert;
    cmd.shift = decide && do_remove;
    cmd.pos = pos;
    cmd.count = count;
    cmd.value = (state == S_IDLE) ? value : value_q;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (decide) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (decide) begin
        count <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q <= mode;
      value_q <= value;
    end
    if (decide) begin
      status <= status_next;
      found <= hit;
      entry_count <= ist_pkg::OUT_CNT_W'(count_next);
      is_empty <= (count_next == '0);
    end
  end

endmodule

@@ test/integer_set_table_test.sv @@
// Self-checking testbench of the integer set table: directed and random requests.
module integer_set_table_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic       found;
    logic [6:0] entry_count;
    logic       is_empty;
  } outcome_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] operand;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED} burst_kind_t;

  localparam int RANDOM_ITEMS = 1930;
  localparam int LONG_STALL_CYCLES = 400;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [1:0]          mode = ist_pkg::MODE_QUERY;
  logic signed [31:0]  value = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [2:0]          status;
  logic                found;
  logic [6:0]          entry_count;
  logic                is_empty;

  logic [31:0] held_values[$];
  logic [31:0] value_pool[$];
  outcome_t    pending_outcomes[$];
  stim_row_t   directed_rows[$];

  int idle_pct = 0;
  int stall_pct = 0;
  int long_stalls_asked = 0;
  int long_stalls_served = 0;
  int stall_left = 0;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int full_count = 0;
  int drained_count = 0;
  outcome_t got;

  integer_set_table dut (.*);

  always #10 clk = ~clk;

  function automatic outcome_t predict_outcome(logic [1:0] op, logic [31:0] operand);
    int pos;
    bit hit;
    outcome_t o;
    pos = -1;
    foreach (held_values[i]) begin
      if (pos < 0 && held_values[i] == operand) pos = i;
    end
    hit = (pos >= 0);
    case (op)
      ist_pkg::MODE_INSERT: begin
        if (hit) begin
          o.status = ist_pkg::ST_PRESENT;
        end else if (held_values.size() >= ist_pkg::CAPACITY) begin
          o.status = ist_pkg::ST_FULL;
          full_count++;
        end else begin
          held_values.push_back(operand);
          o.status = ist_pkg::ST_INSERTED;
        end
      end
      ist_pkg::MODE_REMOVE: begin
        if (hit) begin
          held_values.delete(pos);
          o.status = ist_pkg::ST_REMOVED;
          if (held_values.size() == 0) drained_count++;
        end else begin
          o.status = ist_pkg::ST_ABSENT;
        end
      end
      default: o.status = hit ? ist_pkg::ST_PRESENT : ist_pkg::ST_ABSENT;
    endcase
    o.found = hit;
    o.entry_count = 7'(held_values.size());
    o.is_empty = (held_values.size() == 0);
    return o;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [31:0] operand, bit typed = 1'b0,
                                  logic [2:0] st = ist_pkg::ST_INSERTED, logic f = 1'b0,
                                  logic [6:0] cnt = '0, logic e = 1'b0);
    stim_row_t r;
    r.op = op;
    r.operand = operand;
    r.typed = typed;
    r.want = '{status: st, found: f, entry_count: cnt, is_empty: e};
    directed_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_value(bit for_insert);
    int r;
    r = $urandom_range(99);
    if (held_values.size() != 0 && r < (for_insert ? 20 : 60))
      return held_values[$urandom_range(held_values.size() - 1)];
    if (r < (for_insert ? 75 : 80))
      return $urandom;
    return value_pool[$urandom_range(value_pool.size() - 1)];
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] operand,
                              input bit typed = 1'b0, input outcome_t want = '0);
    int gap;
    outcome_t predicted;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    mode <= op;
    value <= operand;
    do @(posedge clk); while (!req_ready);
    predicted = predict_outcome(op, operand);
    pending_outcomes.push_back(typed ? want : predicted);
    sent_count++;
  endtask

  task automatic random_burst(burst_kind_t kind, int length);
    int r;
    logic [1:0] op;
    repeat (length) begin
      r = $urandom_range(99);
      case (kind)
        BURST_FILL:
          op = (r < 85) ? ist_pkg::MODE_INSERT : (r < 93) ? ist_pkg::MODE_QUERY :
               (r < 97) ? ist_pkg::MODE_REMOVE : ist_pkg::MODE_SPARE;
        BURST_DRAIN:
          op = (r < 80) ? ist_pkg::MODE_REMOVE : (r < 88) ? ist_pkg::MODE_INSERT :
               (r < 95) ? ist_pkg::MODE_QUERY : ist_pkg::MODE_SPARE;
        default:
          op = (r < 30) ? ist_pkg::MODE_INSERT : (r < 60) ? ist_pkg::MODE_REMOVE :
               (r < 90) ? ist_pkg::MODE_QUERY : ist_pkg::MODE_SPARE;
      endcase
      send_request(op, pick_value(op == ist_pkg::MODE_INSERT));
    end
  endtask

  // Responses are sampled at the rising edge; the ready line is redrawn every cycle, but held low during a long stall.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      got = '{status: status, found: found, entry_count: entry_count, is_empty: is_empty};
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected response status=%0d found=%0b count=%0d empty=%0b",
                 $time, got.status, got.found, got.entry_count, got.is_empty);
        error_count++;
      end else begin
        if (got !== pending_outcomes[0]) begin
          $display("%0t: mismatch (status/found/count/empty), expected %0d/%0b/%0d/%0b",
                   $time, pending_outcomes[0].status, pending_outcomes[0].found,
                   pending_outcomes[0].entry_count, pending_outcomes[0].is_empty,
                   ", got %0d/%0b/%0d/%0b",
                   got.status, got.found, got.entry_count, got.is_empty);
          error_count++;
        end
        void'(pending_outcomes.pop_front());
        checked_count++;
      end
    end
    if (long_stalls_served != long_stalls_asked) begin
      long_stalls_served = long_stalls_asked;
      stall_left = LONG_STALL_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("** integer_set_table: FAILED **");
    $finish;
  end

  initial begin
    int random_sent;
    int quota;
    int burst;
    int phase;
    value_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    repeat (76) value_pool.push_back($urandom);

    add_row(ist_pkg::MODE_QUERY,  32'h0000_0000, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd0, 1'b1);
    add_row(ist_pkg::MODE_REMOVE, 32'h7fff_ffff, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd0, 1'b1);
    add_row(ist_pkg::MODE_SPARE,  32'h0000_0000, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd0, 1'b1);
    add_row(ist_pkg::MODE_INSERT, 32'h8000_0000, 1'b1, ist_pkg::ST_INSERTED, 1'b0, 7'd1, 1'b0);
    add_row(ist_pkg::MODE_INSERT, 32'h7fff_ffff, 1'b1, ist_pkg::ST_INSERTED, 1'b0, 7'd2, 1'b0);
    add_row(ist_pkg::MODE_INSERT, 32'h0000_0000, 1'b1, ist_pkg::ST_INSERTED, 1'b0, 7'd3, 1'b0);
    add_row(ist_pkg::MODE_INSERT, 32'hffff_ffff, 1'b1, ist_pkg::ST_INSERTED, 1'b0, 7'd4, 1'b0);
    add_row(ist_pkg::MODE_INSERT, 32'h8000_0000, 1'b1, ist_pkg::ST_PRESENT,  1'b1, 7'd4, 1'b0);
    add_row(ist_pkg::MODE_QUERY,  32'h7fff_ffff, 1'b1, ist_pkg::ST_PRESENT,  1'b1, 7'd4, 1'b0);
    add_row(ist_pkg::MODE_SPARE,  32'hffff_ffff, 1'b1, ist_pkg::ST_PRESENT,  1'b1, 7'd4, 1'b0);
    add_row(ist_pkg::MODE_QUERY,  32'h7fff_fffe, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd4, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'h7fff_ffff, 1'b1, ist_pkg::ST_REMOVED,  1'b1, 7'd3, 1'b0);
    add_row(ist_pkg::MODE_QUERY,  32'h0000_0000, 1'b1, ist_pkg::ST_PRESENT,  1'b1, 7'd3, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'hffff_ffff, 1'b1, ist_pkg::ST_REMOVED,  1'b1, 7'd2, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'hffff_ffff, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd2, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'h8000_0000, 1'b1, ist_pkg::ST_REMOVED,  1'b1, 7'd1, 1'b0);
    add_row(ist_pkg::MODE_INSERT, 32'h0000_0001, 1'b1, ist_pkg::ST_INSERTED, 1'b0, 7'd2, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'h0000_0000, 1'b1, ist_pkg::ST_REMOVED,  1'b1, 7'd1, 1'b0);
    add_row(ist_pkg::MODE_REMOVE, 32'h0000_0001, 1'b1, ist_pkg::ST_REMOVED,  1'b1, 7'd0, 1'b1);
    add_row(ist_pkg::MODE_REMOVE, 32'h0000_0001, 1'b1, ist_pkg::ST_ABSENT,   1'b0, 7'd0, 1'b1);
    add_row(ist_pkg::MODE_INSERT, 32'h5a5a_5a5a);
    add_row(ist_pkg::MODE_INSERT, 32'ha5a5_a5a5);
    add_row(ist_pkg::MODE_QUERY,  32'h5a5a_5a5a);
    add_row(ist_pkg::MODE_REMOVE, 32'h5a5a_5a5a);
    add_row(ist_pkg::MODE_SPARE,  32'ha5a5_a5a5);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].op, directed_rows[i].operand,
                   directed_rows[i].typed, directed_rows[i].want);

    // Four idling settings: none, sender idle, receiver stalling, both lightly.
    random_sent = 0;
    burst = 0;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 67; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 67; end
        default: begin idle_pct = 11; stall_pct <= 11; end
      endcase
      // In the first phase only, the receiver holds off for a long stretch while requests keep coming.
      if (phase == 0) long_stalls_asked <= long_stalls_asked + 1;
      quota = RANDOM_ITEMS * (phase + 1) / 4;
      while (random_sent < quota) begin
        int length;
        length = $urandom_range(40, 120);
        if (burst == 0)
          random_burst(BURST_FILL, 120);
        else
          random_burst(burst_kind_t'($urandom_range(2)), length);
        random_sent += (burst == 0) ? 120 : length;
        burst++;
      end
    end

    req_valid <= 1'b0;
    stall_pct <= 0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d requests in %0d random bursts; %0d responses checked.",
             sent_count, burst, checked_count);
    $display("The table refused inserts when full %0d times and was emptied %0d times.",
             full_count, drained_count);
    if (error_count == 0) begin
      $display("** integer_set_table: PASSED **");
    end else begin
      $display("** integer_set_table: FAILED **");
    end
    $finish;
  end

endmodule
